// ===== rtl/lfpd_pkg.sv =====
// Shared widths, register indexes, reset values and types for the line-follow PID drive.
package lfpd_pkg;

   localparam int SENSOR_BITS_DEF = 12;

   localparam int GAIN_W     = 12;
   localparam int OFFSET_W   = 12;
   localparam int SPEED_W    = 12;
   localparam int COUNT_W    = 32;
   localparam int DIST_W     = 31;
   localparam int INTEG_W    = 25;
   localparam int FRAC_W     = 8;
   localparam int TURN_SHIFT = 17;
   localparam int SPEED_LIMIT = 1500;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_ON_LEFT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_DISTANCE = 3'd6;

   localparam logic [GAIN_W-1:0]          GAIN_P_RST     = 12'd179;
   localparam logic [GAIN_W-1:0]          GAIN_I_RST     = 12'd26;
   localparam logic [GAIN_W-1:0]          GAIN_D_RST     = 12'd256;
   localparam logic [OFFSET_W-1:0]        OFFSET_RST     = 12'd700;
   localparam logic signed [SPEED_W-1:0]  BASE_SPEED_RST = 12'sd1100;
   localparam logic                       LINE_LEFT_RST  = 1'b1;
   localparam logic [DIST_W-1:0]          STOP_DIST_RST  = 31'd0;

   // Error is wide enough for any sample minus any offset.
   function automatic int err_width(input int sensor_bits);
      return ((sensor_bits > OFFSET_W) ? sensor_bits : OFFSET_W) + 1;
   endfunction

   typedef struct packed {
      logic [GAIN_W-1:0]         gain_p;
      logic [GAIN_W-1:0]         gain_i;
      logic [GAIN_W-1:0]         gain_d;
      logic [OFFSET_W-1:0]       sensor_offset;
      logic signed [SPEED_W-1:0] base_speed;
      logic                      line_on_left;
      logic [DIST_W-1:0]         stop_distance;
   } csr_type;

   typedef struct packed {
      logic ld_b;
      logic ld_c;
      logic ld_d;
   } pipe_ctl_type;

endpackage

// ===== rtl/lfpd_loop.sv =====
// Control state (leaky integral, last error, stop latch) and the error stage register.
module lfpd_loop #(
   parameter int SENSOR_BITS = lfpd_pkg::SENSOR_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  lfpd_pkg::pipe_ctl_type                    ctl,
   input  lfpd_pkg::csr_type                         csr,
   input  logic [SENSOR_BITS-1:0]                    sample,
   input  logic signed [lfpd_pkg::COUNT_W-1:0]       left_count,
   input  logic signed [lfpd_pkg::COUNT_W-1:0]       right_count,
   input  logic                                      start_req,
   output logic signed [lfpd_pkg::err_width(SENSOR_BITS)-1:0] err_out,
   output logic signed [lfpd_pkg::INTEG_W-1:0]       integ_out,
   output logic signed [lfpd_pkg::err_width(SENSOR_BITS):0]   deriv_out,
   output logic                                      stop_out
);
   import lfpd_pkg::*;

   localparam int ERR_W = err_width(SENSOR_BITS);
   localparam int DER_W = ERR_W + 1;
   localparam int SUM_W = (((INTEG_W + 3) > (ERR_W + FRAC_W)) ? (INTEG_W + 3)
                                                              : (ERR_W + FRAC_W)) + 2;
   localparam logic signed [SUM_W-1:0] INTEG_HI = SUM_W'((1 << (INTEG_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] INTEG_LO = SUM_W'(-(1 << (INTEG_W - 1)));

   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [ERR_W-1:0]   prev_ff, prev_in;
   logic                      latch_ff, latch_in;

   logic signed [ERR_W-1:0]   err_ff;
   logic signed [INTEG_W-1:0] integ_st_ff;
   logic signed [DER_W-1:0]   deriv_ff;
   logic                      stop_ff;

   logic signed [INTEG_W-1:0] integ_base;
   logic signed [ERR_W-1:0]   prev_base;
   logic signed [ERR_W-1:0]   err;
   logic signed [SUM_W-1:0]   times7;
   logic signed [SUM_W-1:0]   decayed;
   logic signed [SUM_W-1:0]   integ_sum;
   logic signed [INTEG_W-1:0] integ_new;
   logic signed [DER_W-1:0]   deriv;
   logic signed [COUNT_W:0]   lc_x, rc_x;
   logic [COUNT_W:0]          lc_mag, rc_mag;
   logic                      exceed;
   logic                      latch_eff;

   always_comb begin
      // A start request clears the state before this item is used.
      integ_base = start_req ? '0 : integ_ff;
      prev_base  = start_req ? '0 : prev_ff;

      lc_x   = (COUNT_W + 1)'(left_count);
      rc_x   = (COUNT_W + 1)'(right_count);
      lc_mag = lc_x[COUNT_W] ? $unsigned(-lc_x) : $unsigned(lc_x);
      rc_mag = rc_x[COUNT_W] ? $unsigned(-rc_x) : $unsigned(rc_x);
      exceed = (lc_mag > (COUNT_W + 1)'(csr.stop_distance)) ||
               (rc_mag > (COUNT_W + 1)'(csr.stop_distance));
      latch_eff = (latch_ff & ~start_req) | exceed;

      err = $signed(ERR_W'(sample)) - $signed(ERR_W'(csr.sensor_offset));

      // Decay by 7/8 with truncation toward zero.
      times7  = (SUM_W'(integ_base) <<< 3) - SUM_W'(integ_base);
      decayed = times7[SUM_W-1] ? ((times7 + SUM_W'(7)) >>> 3) : (times7 >>> 3);
      integ_sum = decayed + (SUM_W'(err) <<< FRAC_W);
      if (integ_sum > INTEG_HI) begin
         integ_new = INTEG_HI[INTEG_W-1:0];
      end else if (integ_sum < INTEG_LO) begin
         integ_new = INTEG_LO[INTEG_W-1:0];
      end else begin
         integ_new = integ_sum[INTEG_W-1:0];
      end

      deriv = DER_W'(err) - DER_W'(prev_base);

      integ_in = integ_ff;
      prev_in  = prev_ff;
      latch_in = latch_ff;
      if (ctl.ld_b) begin
         latch_in = latch_eff;
         if (!latch_eff) begin
            integ_in = integ_new;
            prev_in  = err;
         end else begin
            integ_in = integ_base;
            prev_in  = prev_base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         prev_ff  <= '0;
         latch_ff <= 1'b0;
      end else begin
         integ_ff <= integ_in;
         prev_ff  <= prev_in;
         latch_ff <= latch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_b) begin
         err_ff      <= err;
         integ_st_ff <= integ_new;
         deriv_ff    <= deriv;
         stop_ff     <= latch_eff;
      end
   end

   assign err_out   = err_ff;
   assign integ_out = integ_st_ff;
   assign deriv_out = deriv_ff;
   assign stop_out  = stop_ff;

endmodule

// ===== rtl/lfpd_turn.sv =====
// Gain products and the turn term, two registered stages.
module lfpd_turn #(
   parameter int SENSOR_BITS = lfpd_pkg::SENSOR_BITS_DEF
) (
   input  logic                                               clock,
   input  lfpd_pkg::pipe_ctl_type                             ctl,
   input  lfpd_pkg::csr_type                                  csr,
   input  logic signed [lfpd_pkg::err_width(SENSOR_BITS)-1:0] err,
   input  logic signed [lfpd_pkg::INTEG_W-1:0]                integ,
   input  logic signed [lfpd_pkg::err_width(SENSOR_BITS):0]   deriv,
   input  logic                                               stop_in,
   output logic signed [lfpd_pkg::INTEG_W + lfpd_pkg::GAIN_W
                        - lfpd_pkg::TURN_SHIFT + 3:0]         turn_out,
   output logic                                               stop_out
);
   import lfpd_pkg::*;

   localparam int ERR_W  = err_width(SENSOR_BITS);
   localparam int DER_W  = ERR_W + 1;
   localparam int PP_W   = GAIN_W + 1 + ERR_W;
   localparam int PI_W   = GAIN_W + 1 + INTEG_W;
   localparam int PD_W   = GAIN_W + 1 + DER_W;
   localparam int ACC_W  = INTEG_W + GAIN_W + 5;
   localparam int TURN_W = INTEG_W + GAIN_W - TURN_SHIFT + 4;
   localparam logic signed [ACC_W-1:0] ROUND_NEG = ACC_W'((1 << TURN_SHIFT) - 1);

   logic signed [PP_W-1:0]   prod_p_ff;
   logic signed [PI_W-1:0]   prod_i_ff;
   logic signed [PD_W-1:0]   prod_d_ff;
   logic                     stop_c_ff;
   logic signed [TURN_W-1:0] turn_ff;
   logic                     stop_d_ff;

   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  acc_adj;
   logic signed [ACC_W-1:0]  acc_sh;

   always_ff @(posedge clock) begin
      if (ctl.ld_c) begin
         prod_p_ff <= $signed({1'b0, csr.gain_p}) * err;
         prod_i_ff <= $signed({1'b0, csr.gain_i}) * integ;
         prod_d_ff <= $signed({1'b0, csr.gain_d}) * deriv;
         stop_c_ff <= stop_in;
      end
   end

   always_comb begin
      // Q.16 sum, then one truncation toward zero by 2^17 covers both halvings.
      acc = (ACC_W'(prod_p_ff) <<< FRAC_W) + ACC_W'(prod_i_ff)
          + (ACC_W'(prod_d_ff) <<< FRAC_W);
      acc_adj = acc[ACC_W-1] ? (acc + ROUND_NEG) : acc;
      acc_sh  = acc_adj >>> TURN_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_d) begin
         turn_ff   <= acc_sh[TURN_W-1:0];
         stop_d_ff <= stop_c_ff;
      end
   end

   assign turn_out = turn_ff;
   assign stop_out = stop_d_ff;

endmodule

// ===== rtl/line_follow_pid_drive.sv =====
// Top level of the line-follow PID drive: registers, pipeline control and wheel mixing.
// An accepted item passes from the input register through the error/integral, gain
// product, turn and result registers in that order before it shows on rsp_valid.
// Throughput is one item per cycle; stall on the result side backs up stage by stage.
// Five register stages: input, error/integral, gain products, turn, result.
// Synchronous active-high reset clears stage valids, the control state and the configuration registers.
module line_follow_pid_drive #(
   parameter int SENSOR_BITS = lfpd_pkg::SENSOR_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_wr_en,
   input  logic [lfpd_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [lfpd_pkg::CSR_DATA_W-1:0]          csr_wr_data,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [SENSOR_BITS-1:0]                   req_sample,
   input  logic signed [lfpd_pkg::COUNT_W-1:0]      req_left_count,
   input  logic signed [lfpd_pkg::COUNT_W-1:0]      req_right_count,
   input  logic                                     req_start_req,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [lfpd_pkg::SPEED_W-1:0]      rsp_right_speed,
   output logic signed [lfpd_pkg::SPEED_W-1:0]      rsp_left_speed,
   output logic                                     rsp_stopped
);
   import lfpd_pkg::*;

   localparam int ERR_W  = err_width(SENSOR_BITS);
   localparam int TURN_W = INTEG_W + GAIN_W - TURN_SHIFT + 4;
   localparam int MIX_W  = TURN_W + 2;
   localparam logic signed [MIX_W-1:0] SPD_HI = MIX_W'(SPEED_LIMIT);
   localparam logic signed [MIX_W-1:0] SPD_LO = MIX_W'(-SPEED_LIMIT);

   // Configuration registers.
   csr_type csr_ff, csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GAIN_P:        csr_in.gain_p        = csr_wr_data[GAIN_W-1:0];
            CSR_GAIN_I:        csr_in.gain_i        = csr_wr_data[GAIN_W-1:0];
            CSR_GAIN_D:        csr_in.gain_d        = csr_wr_data[GAIN_W-1:0];
            CSR_SENSOR_OFFSET: csr_in.sensor_offset = csr_wr_data[OFFSET_W-1:0];
            CSR_BASE_SPEED:    csr_in.base_speed    = $signed(csr_wr_data[SPEED_W-1:0]);
            CSR_LINE_ON_LEFT:  csr_in.line_on_left  = csr_wr_data[0];
            CSR_STOP_DISTANCE: csr_in.stop_distance = csr_wr_data[DIST_W-1:0];
            default: begin
               // Writes beyond the register list are dropped.
               csr_in = csr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.gain_p        <= GAIN_P_RST;
         csr_ff.gain_i        <= GAIN_I_RST;
         csr_ff.gain_d        <= GAIN_D_RST;
         csr_ff.sensor_offset <= OFFSET_RST;
         csr_ff.base_speed    <= BASE_SPEED_RST;
         csr_ff.line_on_left  <= LINE_LEFT_RST;
         csr_ff.stop_distance <= STOP_DIST_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Pipeline control. Each stage loads when it holds nothing or its item moves on,
   // so a stall on the result side only blocks the input once every stage is full.
   logic a_v_ff, b_v_ff, c_v_ff, d_v_ff, o_v_ff;
   logic a_v_in, b_v_in, c_v_in, d_v_in, o_v_in;
   logic o_rdy, d_rdy, c_rdy, b_rdy, a_rdy;
   logic accept, ld_out;
   pipe_ctl_type ctl;

   always_comb begin
      o_rdy    = !o_v_ff || !rsp_stall;
      ld_out   = d_v_ff && o_rdy;
      d_rdy    = !d_v_ff || o_rdy;
      ctl.ld_d = c_v_ff && d_rdy;
      c_rdy    = !c_v_ff || d_rdy;
      ctl.ld_c = b_v_ff && c_rdy;
      b_rdy    = !b_v_ff || c_rdy;
      ctl.ld_b = a_v_ff && b_rdy;
      a_rdy    = !a_v_ff || b_rdy;
      accept   = req_valid && a_rdy;

      a_v_in = accept   ? 1'b1 : (ctl.ld_b ? 1'b0 : a_v_ff);
      b_v_in = ctl.ld_b ? 1'b1 : (ctl.ld_c ? 1'b0 : b_v_ff);
      c_v_in = ctl.ld_c ? 1'b1 : (ctl.ld_d ? 1'b0 : c_v_ff);
      d_v_in = ctl.ld_d ? 1'b1 : (ld_out   ? 1'b0 : d_v_ff);
      o_v_in = ld_out   ? 1'b1 : ((o_v_ff && !rsp_stall) ? 1'b0 : o_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         b_v_ff <= b_v_in;
         c_v_ff <= c_v_in;
         d_v_ff <= d_v_in;
         o_v_ff <= o_v_in;
      end
   end

   assign req_stall = !a_rdy;

   // Input register.
   logic [SENSOR_BITS-1:0]      sample_ff;
   logic signed [COUNT_W-1:0]   left_count_ff;
   logic signed [COUNT_W-1:0]   right_count_ff;
   logic                        start_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff      <= req_sample;
         left_count_ff  <= req_left_count;
         right_count_ff <= req_right_count;
         start_ff       <= req_start_req;
      end
   end

   // Error, leaky integral, derivative and the stop latch. The control state moves
   // forward as each item leaves the input register, so successive items chain
   // through it in the order they arrive.
   logic signed [ERR_W-1:0]   err_b;
   logic signed [INTEG_W-1:0] integ_b;
   logic signed [ERR_W:0]     deriv_b;
   logic                      stop_b;

   lfpd_loop #(
      .SENSOR_BITS(SENSOR_BITS)
   ) u_loop (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .csr         (csr_ff),
      .sample      (sample_ff),
      .left_count  (left_count_ff),
      .right_count (right_count_ff),
      .start_req   (start_ff),
      .err_out     (err_b),
      .integ_out   (integ_b),
      .deriv_out   (deriv_b),
      .stop_out    (stop_b)
   );

   // Three gain products, then their sum reduced to the turn term.
   logic signed [TURN_W-1:0] turn_d;
   logic                     stop_d;

   lfpd_turn #(
      .SENSOR_BITS(SENSOR_BITS)
   ) u_turn (
      .clock    (clock),
      .ctl      (ctl),
      .csr      (csr_ff),
      .err      (err_b),
      .integ    (integ_b),
      .deriv    (deriv_b),
      .stop_in  (stop_b),
      .turn_out (turn_d),
      .stop_out (stop_d)
   );

   // Wheel mixing: the turn goes to the right wheel with a plus sign when the
   // line is on the left. Both speeds saturate; a stopped run brakes both wheels.
   logic signed [MIX_W-1:0]   turn_signed;
   logic signed [MIX_W-1:0]   right_sum, left_sum;
   logic signed [SPEED_W-1:0] right_sat, left_sat;
   logic signed [SPEED_W-1:0] right_ff, left_ff;
   logic                      stopped_ff;

   always_comb begin
      turn_signed = csr_ff.line_on_left ? MIX_W'(turn_d) : -MIX_W'(turn_d);
      right_sum   = MIX_W'(csr_ff.base_speed) + turn_signed;
      left_sum    = MIX_W'(csr_ff.base_speed) - turn_signed;

      if (right_sum > SPD_HI) begin
         right_sat = SPD_HI[SPEED_W-1:0];
      end else if (right_sum < SPD_LO) begin
         right_sat = SPD_LO[SPEED_W-1:0];
      end else begin
         right_sat = right_sum[SPEED_W-1:0];
      end

      if (left_sum > SPD_HI) begin
         left_sat = SPD_HI[SPEED_W-1:0];
      end else if (left_sum < SPD_LO) begin
         left_sat = SPD_LO[SPEED_W-1:0];
      end else begin
         left_sat = left_sum[SPEED_W-1:0];
      end

      if (stop_d) begin
         right_sat = '0;
         left_sat  = '0;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (ld_out) begin
         right_ff   <= right_sat;
         left_ff    <= left_sat;
         stopped_ff <= stop_d;
      end
   end

   assign rsp_valid       = o_v_ff;
   assign rsp_right_speed = right_ff;
   assign rsp_left_speed  = left_ff;
   assign rsp_stopped     = stopped_ff;

endmodule

// ===== bench/tb_line_follow_pid_drive.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the line-follow PID drive, with directed and random items.
module tb_line_follow_pid_drive;
   import lfpd_pkg::*;

   localparam int SAMPLE_W     = SENSOR_BITS_DEF;
   // Extra wait in settle_block once every command is in; this covers the
   // pipeline with margin.
   localparam int DRAIN_CYCLES = 10;
   localparam int IDLE_PERCENT = 22;
   localparam int PRINT_LIMIT  = 40;

   localparam longint INTEG_HI = 64'sd16777215;
   localparam longint INTEG_LO = -64'sd16777216;

   // One item as it goes into the block.
   typedef struct {
      logic [SAMPLE_W-1:0]       sample;
      logic signed [COUNT_W-1:0] left_count;
      logic signed [COUNT_W-1:0] right_count;
      logic                      start_req;
   } drive_item_type;

   // One wheel command as it comes out of the block.
   typedef struct {
      logic signed [SPEED_W-1:0] right_cmd;
      logic signed [SPEED_W-1:0] left_cmd;
      logic                      stopped;
   } wheel_cmd_type;

   // Every input of the block starts at a known value.
   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      csr_wr_en       = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index       = '0;
   logic [CSR_DATA_W-1:0]     csr_wr_data     = '0;
   logic                      req_valid       = 1'b0;
   logic                      req_stall;
   logic [SAMPLE_W-1:0]       req_sample      = '0;
   logic signed [COUNT_W-1:0] req_left_count  = '0;
   logic signed [COUNT_W-1:0] req_right_count = '0;
   logic                      req_start_req   = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall       = 1'b0;
   logic signed [SPEED_W-1:0] rsp_right_speed;
   logic signed [SPEED_W-1:0] rsp_left_speed;
   logic                      rsp_stopped;

   // The predictor's own copy of the registers, starting at the reset values.
   logic [GAIN_W-1:0]         kp_mirror        = GAIN_P_RST;
   logic [GAIN_W-1:0]         ki_mirror        = GAIN_I_RST;
   logic [GAIN_W-1:0]         kd_mirror        = GAIN_D_RST;
   logic [OFFSET_W-1:0]       offset_mirror    = OFFSET_RST;
   logic signed [SPEED_W-1:0] base_mirror      = BASE_SPEED_RST;
   logic                      line_left_mirror = LINE_LEFT_RST;
   logic [DIST_W-1:0]         stop_dist_mirror = STOP_DIST_RST;

   // The predictor's own copy of the controller state.
   longint integral_q8  = 0;
   longint prev_err_q0  = 0;
   bit     run_stopped  = 1'b0;

   wheel_cmd_type pending_cmds[$];
   int            mismatch_count = 0;
   // When this is low, neither side inserts idle cycles.
   bit            idle_on = 1'b1;

   line_follow_pid_drive u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_left_count  (req_left_count),
      .req_right_count (req_right_count),
      .req_start_req   (req_start_req),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_right_speed (rsp_right_speed),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_stopped     (rsp_stopped)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A hung handshake must not keep the run going forever.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Computes the wheel command for one item and advances the controller state.
   // Signed division in SystemVerilog truncates toward zero, which is what the
   // integral decay and the turn scaling need.
   function automatic wheel_cmd_type predict_wheel_cmd(input drive_item_type it);
      longint        smp, lc, rc, lmag, rmag, err, integ, deriv, acc, turn, right, left;
      wheel_cmd_type cmd;
      smp  = longint'(it.sample);
      lc   = longint'(it.left_count);
      rc   = longint'(it.right_count);
      lmag = (lc < 0) ? -lc : lc;
      rmag = (rc < 0) ? -rc : rc;
      right = 0;
      left  = 0;
      // A start request clears the run before this item is looked at.
      if (it.start_req) begin
         integral_q8 = 0;
         prev_err_q0 = 0;
         run_stopped = 1'b0;
      end
      // Distance is checked first; the most negative count has magnitude 2^31 here.
      if (lmag > longint'(stop_dist_mirror) || rmag > longint'(stop_dist_mirror))
         run_stopped = 1'b1;
      // While stopped, both speeds are zero and the loop state is frozen.
      if (!run_stopped) begin
         err   = smp - longint'(offset_mirror);
         integ = clamp((integral_q8 * 7) / 8 + err * 256, INTEG_LO, INTEG_HI);
         deriv = err - prev_err_q0;
         acc   = longint'(kp_mirror) * err * 256 + longint'(ki_mirror) * integ
                 + longint'(kd_mirror) * deriv * 256;
         turn  = (acc / 65536) / 2;
         if (!line_left_mirror)
            turn = -turn;
         // A base speed outside the limits is used as is; only the sums saturate.
         right = clamp(longint'(base_mirror) + turn, -SPEED_LIMIT, SPEED_LIMIT);
         left  = clamp(longint'(base_mirror) - turn, -SPEED_LIMIT, SPEED_LIMIT);
         integral_q8 = integ;
         prev_err_q0 = err;
      end
      cmd.right_cmd = right[SPEED_W-1:0];
      cmd.left_cmd  = left[SPEED_W-1:0];
      cmd.stopped   = run_stopped;
      return cmd;
   endfunction

   function automatic drive_item_type make_item(input logic [SAMPLE_W-1:0] sample,
                                                input logic signed [COUNT_W-1:0] lc,
                                                input logic signed [COUNT_W-1:0] rc,
                                                input logic start);
      drive_item_type it;
      it.sample      = sample;
      it.left_count  = lc;
      it.right_count = rc;
      it.start_req   = start;
      return it;
   endfunction

   // Places a register value in the low bits and random junk above it, which
   // the block must ignore.
   function automatic logic [CSR_DATA_W-1:0] with_junk(input logic [CSR_DATA_W-1:0] value,
                                                       input int width);
      logic [CSR_DATA_W-1:0] data;
      logic [CSR_DATA_W-1:0] mask;
      data = CSR_DATA_W'($urandom);
      mask = (width >= CSR_DATA_W) ? '1 : ((31'd1 << width) - 31'd1);
      return (data & ~mask) | (value & mask);
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // Writes one register and keeps the predictor's copy in step. The block is
   // idle whenever this is called.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_GAIN_P:        kp_mirror        = data[GAIN_W-1:0];
         CSR_GAIN_I:        ki_mirror        = data[GAIN_W-1:0];
         CSR_GAIN_D:        kd_mirror        = data[GAIN_W-1:0];
         CSR_SENSOR_OFFSET: offset_mirror    = data[OFFSET_W-1:0];
         CSR_BASE_SPEED:    base_mirror      = signed'(data[SPEED_W-1:0]);
         CSR_LINE_ON_LEFT:  line_left_mirror = data[0];
         CSR_STOP_DISTANCE: stop_dist_mirror = data[DIST_W-1:0];
         default: ;
      endcase
   endtask

   // Offers one item, with random idle cycles first, and holds it until the
   // block takes it. The valid is left high so that a following item can go
   // out back to back; whoever comes next lowers it if needed.
   task automatic send_item(input drive_item_type it);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample      <= it.sample;
      req_left_count  <= it.left_count;
      req_right_count <= it.right_count;
      req_start_req   <= it.start_req;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_cmds.push_back(predict_wheel_cmd(it));
   endtask

   // Stops sending, waits for every expected command and lets the pipeline empty.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The receiver stalls at random, except while idling is switched off.
   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
   end

   // Every command taken from the block is matched against the oldest prediction.
   always @(posedge clock) begin : check_commands
      wheel_cmd_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cmds.size() == 0) begin
            report_mismatch("unexpected command", rsp_right_speed, 0);
         end else begin
            want = pending_cmds.pop_front();
            if (rsp_right_speed !== want.right_cmd)
               report_mismatch("right wheel speed", rsp_right_speed, want.right_cmd);
            if (rsp_left_speed !== want.left_cmd)
               report_mismatch("left wheel speed", rsp_left_speed, want.left_cmd);
            if (rsp_stopped !== want.stopped)
               report_mismatch("stopped", rsp_stopped, want.stopped);
         end
      end
   end

   // With the reset settings the stop distance is zero, so only zero counts
   // keep the run going. This covers the error extremes, the stop latch
   // holding, and a start request that is stopped again by its own counts.
   task automatic test_reset_defaults();
      send_item(make_item(12'd700, 0, 0, 1'b1));
      send_item(make_item(12'd4095, 0, 0, 1'b0));
      send_item(make_item(12'd0, 0, 0, 1'b0));
      send_item(make_item(12'd0, 0, 0, 1'b0));
      send_item(make_item(12'd2048, 0, 0, 1'b0));
      send_item(make_item(12'd1000, 1, 0, 1'b0));
      send_item(make_item(12'd1000, 0, 0, 1'b0));
      send_item(make_item(12'd700, 0, 0, 1'b1));
      send_item(make_item(12'd500, 0, -1, 1'b1));
   endtask

   // Register extremes: full gains, both offset ends, base speeds at and past
   // the limits, both line sides, and the largest and a small stop distance.
   task automatic test_register_extremes();
      settle_block();
      csr_write(CSR_GAIN_P, 31'd4095);
      csr_write(CSR_GAIN_I, 31'd4095);
      csr_write(CSR_GAIN_D, 31'd4095);
      csr_write(CSR_SENSOR_OFFSET, 31'd0);
      csr_write(CSR_BASE_SPEED, 31'd1500);
      csr_write(CSR_LINE_ON_LEFT, 31'd0);
      csr_write(CSR_STOP_DISTANCE, 31'h7FFF_FFFF);
      send_item(make_item(12'd4095, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1));
      send_item(make_item(12'd0, 32'sh8000_0001, 32'sh7FFF_FFFF, 1'b0));
      send_item(make_item(12'd4095, 0, 0, 1'b0));
      // The most negative count is beyond even the largest stop distance.
      send_item(make_item(12'd0, 32'sh8000_0000, 0, 1'b0));
      send_item(make_item(12'd4095, 0, 32'sh8000_0000, 1'b1));

      settle_block();
      csr_write(CSR_GAIN_P, 31'd0);
      csr_write(CSR_GAIN_I, 31'd0);
      csr_write(CSR_GAIN_D, 31'd0);
      csr_write(CSR_SENSOR_OFFSET, 31'd4095);
      csr_write(CSR_BASE_SPEED, 31'h7FF);
      csr_write(CSR_LINE_ON_LEFT, 31'd1);
      csr_write(CSR_STOP_DISTANCE, 31'd100);
      // A count equal to the distance does not stop; one more does.
      send_item(make_item(12'd0, 32'sd100, -32'sd100, 1'b1));
      send_item(make_item(12'd4095, 32'sd101, 0, 1'b0));

      settle_block();
      csr_write(CSR_GAIN_P, 31'd256);
      csr_write(CSR_BASE_SPEED, 31'h800);
      send_item(make_item(12'd4095, 0, 0, 1'b1));
      send_item(make_item(12'd0, 0, -32'sd101, 1'b0));
   endtask

   // Writes every register with a random value for the next random phase.
   task automatic randomize_registers();
      int sel;
      int base;
      logic [CSR_DATA_W-1:0] stop_dist_val;
      sel = $urandom_range(3);
      csr_write(CSR_GAIN_P, with_junk(CSR_DATA_W'((sel == 0) ? $urandom_range(4095)
                                                              : $urandom_range(600)),
                                      GAIN_W));
      csr_write(CSR_GAIN_I, with_junk(CSR_DATA_W'((sel == 0) ? $urandom_range(4095)
                                                              : $urandom_range(100)),
                                      GAIN_W));
      csr_write(CSR_GAIN_D, with_junk(CSR_DATA_W'((sel == 0) ? $urandom_range(4095)
                                                              : $urandom_range(600)),
                                      GAIN_W));
      csr_write(CSR_SENSOR_OFFSET, with_junk(CSR_DATA_W'($urandom_range(4095)), OFFSET_W));
      // Mostly a legal base speed, now and then any 12-bit value.
      if ($urandom_range(4) == 0)
         base = int'($urandom_range(4095));
      else
         base = int'($urandom_range(3000)) - 1500;
      csr_write(CSR_BASE_SPEED, with_junk(CSR_DATA_W'(base), SPEED_W));
      csr_write(CSR_LINE_ON_LEFT, with_junk(CSR_DATA_W'($urandom_range(1)), 1));
      // Stop distance: mostly reachable by a run, sometimes huge, sometimes zero.
      case ($urandom_range(7))
         0:       stop_dist_val = 31'd0;
         1:       stop_dist_val = 31'h7FFF_FFFF;
         2, 3:    stop_dist_val = CSR_DATA_W'($urandom);
         default: stop_dist_val = CSR_DATA_W'($urandom_range(2000, 200));
      endcase
      csr_write(CSR_STOP_DISTANCE, stop_dist_val);
   endtask

   // Random phases. Most items form runs: a start request, then counts that
   // creep away from zero in a random direction, so that the integral and
   // derivative build up and the stop distance is eventually crossed. About
   // one item in eight is noise with every field random.
   task automatic test_random_runs();
      int phase, sent, run_len, stride, lc, rc, ldir, rdir, k;
      for (phase = 0; phase < 12; phase++) begin
         settle_block();
         randomize_registers();
         // One phase runs with no idling on either side.
         idle_on = (phase != 4);
         sent = 0;
         while (sent < 64) begin
            run_len = $urandom_range(30, 5);
            stride  = $urandom_range(100, 1);
            ldir    = $urandom_range(1) ? 1 : -1;
            rdir    = $urandom_range(1) ? 1 : -1;
            lc = 0;
            rc = 0;
            send_item(make_item(SAMPLE_W'($urandom), 0, 0, 1'b1));
            sent++;
            for (k = 0; k < run_len; k++) begin
               if ($urandom_range(7) == 0) begin
                  send_item(make_item(SAMPLE_W'($urandom), $urandom, $urandom,
                                      1'($urandom_range(1))));
               end else begin
                  lc += ldir * int'($urandom_range(stride));
                  rc += rdir * int'($urandom_range(stride));
                  send_item(make_item(SAMPLE_W'($urandom), lc, rc, 1'b0));
               end
               sent++;
               // The sender holds off at most once until the block has answered everything.
               if (phase == 2 && sent == 30)
                  settle_block();
            end
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_register_extremes();
      test_random_runs();
      settle_block();
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
